// File: rtl/core/aptp_pkg.sv
// Package with constants and types of the audio packet timeline placer.
package aptp_pkg;

  localparam int unsigned NumSourcesDefault = 3;
  localparam logic [31:0] MaxCorrReset      = 32'd480;
  localparam logic [7:0]  JitterTolReset    = 8'd2;
  localparam logic [31:0] CanonRateReset    = 32'd48000;
  localparam logic [31:0] TicksPerSecReset  = 32'd10000000;

  localparam logic [1:0] RegMaxCorr   = 2'd0;
  localparam logic [1:0] RegJitterTol = 2'd1;
  localparam logic [1:0] RegCanonRate = 2'd2;
  localparam logic [1:0] RegTicksSec  = 2'd3;

  typedef struct packed {
    logic [1:0]  source_index;
    logic [63:0] timestamp_ticks;
    logic [63:0] device_position;
    logic [31:0] source_rate;
    logic [31:0] packet_frames;
    logic        discontinuity_flag;
    logic        timestamp_good;
  } pkt_in_t;

  typedef struct packed {
    logic [63:0] place_frame;
    logic [63:0] silence_frames;
    logic [31:0] drop_frames;
    logic [63:0] cursor_after;
    logic        timestamp_error_seen;
    logic        drift_corrected;
    logic [7:0]  jitter_snapped;
    logic        late_packet;
  } pkt_out_t;

  // Request and status between the sequencer and the serial scaler.
  typedef struct packed {
    logic        start;
    logic [63:0] value;
    logic [31:0] mult;
    logic [31:0] divisor;
  } scale_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } scale_rsp_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] abs_diff64(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

// File: rtl/core/aptp_if.sv
// Valid/ready channel interface carrying one payload.
interface aptp_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/aptp_scaler.sv
// Bit-serial rounded scaler: round(value * mult / divisor), 0 on overflow or zero divisor.
module aptp_scaler
  import aptp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scale_req_t req_i,
  output scale_rsp_t rsp_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e      state_q;
  logic [6:0]  cnt_q;
  logic [95:0] prod_q;
  logic [63:0] val_q;
  logic [31:0] mult_q;
  logic [31:0] div_q;
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [63:0] res_q;

  // One multiplier bit per cycle, then one quotient bit per cycle.
  logic [95:0] prod_add;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [32:0] half_up;
  logic        round_up;

  assign prod_add = mult_q[0] ? prod_q + ({32'd0, val_q} << cnt_q[4:0]) : prod_q;
  assign rem_sh   = {rem_q[31:0], prod_q[63]};
  assign rem_sub  = rem_sh - {1'b0, div_q};
  // Round up when remainder >= divisor - floor(divisor/2).
  assign half_up  = {1'b0, div_q} - {2'b0, div_q[31:1]};
  assign round_up = rem_q >= half_up;

  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.result = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            val_q   <= req_i.value;
            mult_q  <= req_i.mult;
            div_q   <= req_i.divisor;
            prod_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= prod_add;
          mult_q <= mult_q >> 1;
          cnt_q  <= cnt_q + 7'd1;
          if (cnt_q == 7'd31) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (prod_add[95:64] != 32'd0 || prod_q[95:64] != 32'd0 || div_q == 32'd0) begin
            res_q   <= '0;
            state_q <= S_DONE;
          end else begin
            prod_q <= {prod_q[95:64], prod_q[62:0], 1'b0};
            if (rem_sh >= {1'b0, div_q}) begin
              rem_q <= rem_sub;
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[62:0], 1'b0};
            end
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'd64) begin
              res_q   <= quo_q + {63'd0, round_up};
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/audio_packet_timeline_placer.sv
// Top level of the audio packet timeline placer.
//
// Usage: packet requests enter on in_if (valid/ready); one placement result per
// request leaves on out_if. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while the block is idle,
// which the block itself does not enforce. Processing: a request with a reliable
// timestamp runs three rounded scalings (timestamp frame, device frame, device
// delta) on one bit-serial scaler; a request with an unreliable timestamp runs only
// the timestamp scaling. Each scaling has a multiply phase and a divide phase; an
// overflowing product or a zero divisor ends the divide phase early.
// Throughput: one request at a time; a new request is taken only after the previous
// result has been taken.
// Reset: all sources unstarted, origin unset, cursors zero, registers at defaults.
// If the receiver stalls, the result is held in the output register and the next
// request waits in input (ready low) until the output is taken.
module audio_packet_timeline_placer
  import aptp_pkg::*;
#(
  parameter int unsigned NUM_SOURCES = NumSourcesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aptp_if.sink        in_if,
  aptp_if.source      out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned SrcW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TS, ST_TS_W, ST_DEV, ST_DEV_W, ST_DLT, ST_DLT_W, ST_PLACE, ST_OUT
  } state_e;

  // Configuration registers.
  logic [31:0] max_corr_q, canon_rate_q, ticks_sec_q;
  logic [7:0]  jit_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_corr_q   <= MaxCorrReset;
      jit_tol_q    <= JitterTolReset;
      canon_rate_q <= CanonRateReset;
      ticks_sec_q  <= TicksPerSecReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxCorr:   max_corr_q   <= cfg_wdata_i;
        RegJitterTol: jit_tol_q    <= cfg_wdata_i[7:0];
        RegCanonRate: canon_rate_q <= cfg_wdata_i;
        RegTicksSec:  ticks_sec_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-source state.
  logic        origin_set_q;
  logic [63:0] origin_q;
  logic [NUM_SOURCES-1:0] started_q, prev_valid_q, prev_cont_q;
  logic [63:0] first_dev_q   [NUM_SOURCES];
  logic [63:0] first_frame_q [NUM_SOURCES];
  logic [63:0] prev_dev_q    [NUM_SOURCES];
  logic [31:0] prev_frames_q [NUM_SOURCES];
  logic [31:0] prev_rate_q   [NUM_SOURCES];
  logic [63:0] cursor_q      [NUM_SOURCES];

  state_e      state_q;
  pkt_in_t     pkt_q;
  pkt_out_t    res_q;
  logic [SrcW-1:0] src_q;
  logic [63:0] ts_frame_q, dev_frame_q, delta_q, first_dev_l_q, first_frame_l_q;
  logic        started_l_q;

  scale_req_t  sreq;
  scale_rsp_t  srsp;

  aptp_scaler u_scaler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = (state_q == ST_OUT);
  assign out_if.data  = res_q;

  // Source state for the current request, with first-packet values applied.
  logic [63:0] cur;
  logic [63:0] origin_eff;
  logic        dev_ok;
  assign cur        = cursor_q[src_q];
  assign origin_eff = origin_q;
  assign dev_ok     = (pkt_q.source_rate != 32'd0) &&
                      (pkt_q.device_position >= first_dev_l_q);

  // Scaler request per phase.
  always_comb begin
    sreq         = '0;
    sreq.mult    = canon_rate_q;
    unique case (state_q)
      ST_TS: begin
        sreq.start   = 1'b1;
        sreq.value   = pkt_q.timestamp_ticks - origin_eff;
        sreq.divisor = ticks_sec_q;
      end
      ST_DEV: begin
        sreq.start   = 1'b1;
        sreq.value   = pkt_q.device_position - first_dev_l_q;
        sreq.divisor = pkt_q.source_rate;
      end
      ST_DLT: begin
        sreq.start   = 1'b1;
        sreq.value   = pkt_q.device_position - prev_dev_q[src_q];
        sreq.divisor = pkt_q.source_rate;
      end
      default: ;
    endcase
  end

  // Placement arithmetic on registered scaler results.
  logic [63:0] frame, pend, behind, cd, tol, dd;
  logic        drift, dev_cont, snap;
  pkt_out_t    res_d;
  logic [63:0] cursor_d;
  always_comb begin
    drift = abs_diff64(ts_frame_q, dev_frame_q) > {32'd0, max_corr_q};
    frame = ts_frame_q;
    if (drift) begin
      frame = (dev_frame_q > ts_frame_q) ? ts_frame_q + {32'd0, max_corr_q}
                                         : ts_frame_q - {32'd0, max_corr_q};
    end
    tol = (pkt_q.source_rate == canon_rate_q) ? 64'd0 : {56'd0, jit_tol_q};
    dd  = abs_diff64(delta_q, {32'd0, prev_frames_q[src_q]});
    dev_cont = !pkt_q.discontinuity_flag && prev_valid_q[src_q] && prev_cont_q[src_q] &&
               (pkt_q.source_rate != 32'd0) && (pkt_q.source_rate == prev_rate_q[src_q]) &&
               (pkt_q.device_position >= prev_dev_q[src_q]) && (dd <= tol);
    cd   = abs_diff64(ts_frame_q, cur);
    snap = dev_cont && (cd <= {56'd0, jit_tol_q});
    if (snap) frame = cur;
    pend   = sat_add64(frame, {32'd0, pkt_q.packet_frames});
    behind = cur - frame;

    // Result and new cursor for the current request.
    res_d    = '0;
    cursor_d = cur;
    if (!pkt_q.timestamp_good) begin
      res_d.timestamp_error_seen = 1'b1;
      res_d.place_frame          = cur;
      cursor_d                   = sat_add64(cur, {32'd0, pkt_q.packet_frames});
    end else begin
      res_d.drift_corrected = drift;
      res_d.jitter_snapped  = snap ? cd[7:0] : 8'd0;
      if (frame < cur) begin
        res_d.late_packet = 1'b1;
        res_d.drop_frames = (behind < {32'd0, pkt_q.packet_frames})
                            ? behind[31:0] : pkt_q.packet_frames;
        res_d.place_frame = cur;
        if (pend > cur) cursor_d = pend;
      end else begin
        res_d.place_frame    = frame;
        res_d.silence_frames = frame - cur;
        cursor_d             = pend;
      end
    end
    res_d.cursor_after = cursor_d;
  end

  // Sequencer: one request at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      origin_set_q <= 1'b0;
      origin_q     <= '0;
      started_q    <= '0;
      prev_valid_q <= '0;
      prev_cont_q  <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        cursor_q[i]      <= '0;
        first_dev_q[i]   <= '0;
        first_frame_q[i] <= '0;
        prev_dev_q[i]    <= '0;
        prev_frames_q[i] <= '0;
        prev_rate_q[i]   <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            pkt_q <= in_if.data;
            src_q <= ({30'd0, in_if.data.source_index} < NUM_SOURCES)
                     ? SrcW'(in_if.data.source_index) : '0;
            if (!origin_set_q) begin
              origin_set_q <= 1'b1;
              origin_q     <= in_if.data.timestamp_ticks;
            end
            state_q <= ST_TS;
          end
        end
        ST_TS: begin
          started_l_q     <= started_q[src_q];
          first_dev_l_q   <= started_q[src_q] ? first_dev_q[src_q] : pkt_q.device_position;
          first_frame_l_q <= first_frame_q[src_q];
          state_q         <= ST_TS_W;
        end
        ST_TS_W: begin
          if (srsp.done) begin
            ts_frame_q <= (pkt_q.timestamp_ticks < origin_q) ? 64'd0 : srsp.result;
            if (!started_l_q) begin
              first_frame_l_q <= (pkt_q.timestamp_ticks < origin_q) ? 64'd0 : srsp.result;
            end
            state_q <= pkt_q.timestamp_good ? ST_DEV : ST_PLACE;
          end
        end
        ST_DEV: state_q <= ST_DEV_W;
        ST_DEV_W: begin
          if (srsp.done) begin
            dev_frame_q <= sat_add64(first_frame_l_q, srsp.result);
            state_q     <= ST_DLT;
          end
        end
        ST_DLT: begin
          if (!dev_ok) dev_frame_q <= ts_frame_q;
          state_q <= ST_DLT_W;
        end
        ST_DLT_W: begin
          if (srsp.done) begin
            delta_q <= srsp.result;
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          res_q                <= res_d;
          cursor_q[src_q]      <= cursor_d;
          started_q[src_q]     <= 1'b1;
          first_dev_q[src_q]   <= first_dev_l_q;
          first_frame_q[src_q] <= first_frame_l_q;
          prev_valid_q[src_q]  <= pkt_q.source_rate != 32'd0;
          prev_cont_q[src_q]   <= pkt_q.timestamp_good && !pkt_q.discontinuity_flag;
          prev_dev_q[src_q]    <= pkt_q.device_position;
          prev_frames_q[src_q] <= pkt_q.packet_frames;
          prev_rate_q[src_q]   <= pkt_q.source_rate;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_if.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/aptp_checker.sv
// Port-level checker for the timeline placer, bound to the top level.
module aptp_checker
  import aptp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pkt_out_t out_data
);

  // A result waiting for the receiver holds its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed while stalled");

  // No new request is taken while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken with result pending");

  // An accepted request does not produce a result in the next cycle.
  a_not_immediate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  // Unreliable path never reports late, drift or drop.
  a_bad_ts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.timestamp_error_seen |->
      !out_data.late_packet && !out_data.drift_corrected && out_data.drop_frames == 32'd0)
    else $error("unreliable path reported placement flags");

endmodule

bind audio_packet_timeline_placer aptp_checker u_aptp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

// File: sim/aptp_placement_checker.sv
// Placement checker: predicts each packet's timeline placement and compares the block's results.
`timescale 1ns / 1ps

module aptp_placement_checker
  import aptp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  pkt_in_t     req_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  pkt_out_t    res_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned mismatch_count_o,
  output int unsigned placements_pending_o,
  output int unsigned placements_checked_o
);

  localparam int unsigned NSrc = NumSourcesDefault;
  localparam logic [63:0] AllOnes = '1;

  // Register copies.
  logic [31:0] max_corr_q;
  logic [7:0]  jitter_tol_q;
  logic [31:0] canon_rate_q;
  logic [31:0] ticks_sec_q;

  // Timeline state.
  logic        origin_valid;
  logic [63:0] origin_tick;
  logic        started      [NSrc];
  logic [63:0] first_dev    [NSrc];
  logic [63:0] first_frame  [NSrc];
  logic        last_valid   [NSrc];
  logic [63:0] last_dev     [NSrc];
  logic [31:0] last_frames  [NSrc];
  logic [31:0] last_rate    [NSrc];
  logic        last_contig  [NSrc];
  logic [63:0] cursor       [NSrc];

  pkt_out_t placements_due[$];

  // Rounded scaling floor((v*n + floor(d/2)) / d); zero on zero divisor or overflow.
  function automatic logic [63:0] rounded_scale(logic [63:0] v, logic [63:0] n,
                                                logic [63:0] d);
    logic [63:0] p, q, r, h;
    if (d == 0) return '0;
    if (n != 0 && v > AllOnes / n) return '0;
    p = v * n;
    q = p / d;
    r = p % d;
    h = d >> 1;
    if (r >= d - h) q = q + 1;
    return q;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    return (b > AllOnes - a) ? AllOnes : a + b;
  endfunction

  function automatic logic [63:0] distance(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] tick_frame(logic [63:0] t);
    if (t < origin_tick) return '0;
    return rounded_scale(t - origin_tick, {32'd0, canon_rate_q}, {32'd0, ticks_sec_q});
  endfunction

  // Advances the timeline state by one packet and returns its placement.
  function automatic pkt_out_t place_packet(pkt_in_t p);
    pkt_out_t o;
    int s;
    logic [63:0] ts_f, dev_f, frame, cur, delta, tol, cd, pend, behind;
    logic dev_contig;
    o = '0;
    dev_contig = 1'b0;
    s = (p.source_index < NSrc) ? int'(p.source_index) : 0;
    if (!origin_valid) begin
      origin_valid = 1'b1;
      origin_tick = p.timestamp_ticks;
    end
    if (!started[s]) begin
      started[s] = 1'b1;
      first_dev[s] = p.device_position;
      first_frame[s] = tick_frame(p.timestamp_ticks);
    end
    cur = cursor[s];
    if (!p.timestamp_good) begin
      o.timestamp_error_seen = 1'b1;
      o.place_frame = cur;
      cursor[s] = add_sat(cur, {32'd0, p.packet_frames});
    end else begin
      ts_f = tick_frame(p.timestamp_ticks);
      if (p.source_rate == 0 || p.device_position < first_dev[s]) dev_f = ts_f;
      else dev_f = add_sat(first_frame[s],
                           rounded_scale(p.device_position - first_dev[s],
                                         {32'd0, canon_rate_q}, {32'd0, p.source_rate}));
      frame = ts_f;
      // Drift beyond the limit is pulled toward the device frame.
      if (distance(ts_f, dev_f) > {32'd0, max_corr_q}) begin
        o.drift_corrected = 1'b1;
        frame = (dev_f > ts_f) ? ts_f + {32'd0, max_corr_q} : ts_f - {32'd0, max_corr_q};
      end
      if (!p.discontinuity_flag && last_valid[s] && last_contig[s] && p.source_rate != 0 &&
          p.source_rate == last_rate[s] && p.device_position >= last_dev[s]) begin
        delta = rounded_scale(p.device_position - last_dev[s], {32'd0, canon_rate_q},
                              {32'd0, p.source_rate});
        tol = (p.source_rate == canon_rate_q) ? 64'd0 : {56'd0, jitter_tol_q};
        dev_contig = distance(delta, {32'd0, last_frames[s]}) <= tol;
      end
      // Contiguous packets snap small timestamp wobble onto the cursor.
      if (dev_contig) begin
        cd = distance(ts_f, cur);
        if (cd <= {56'd0, jitter_tol_q}) begin
          o.jitter_snapped = cd[7:0];
          frame = cur;
        end
      end
      if (frame < cur) begin
        pend = add_sat(frame, {32'd0, p.packet_frames});
        behind = cur - frame;
        o.late_packet = 1'b1;
        o.drop_frames = (behind < {32'd0, p.packet_frames}) ? behind[31:0] : p.packet_frames;
        o.place_frame = cur;
        if (pend > cur) cursor[s] = pend;
      end else begin
        o.place_frame = frame;
        o.silence_frames = frame - cur;
        cursor[s] = add_sat(frame, {32'd0, p.packet_frames});
      end
    end
    last_valid[s] = p.source_rate != 0;
    last_dev[s] = p.device_position;
    last_frames[s] = p.packet_frames;
    last_rate[s] = p.source_rate;
    last_contig[s] = p.timestamp_good && !p.discontinuity_flag;
    o.cursor_after = cursor[s];
    return o;
  endfunction

  // Tracks registers, predicts on accepted requests, compares accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    pkt_out_t due;
    if (!rst_ni) begin
      max_corr_q = MaxCorrReset;
      jitter_tol_q = JitterTolReset;
      canon_rate_q = CanonRateReset;
      ticks_sec_q = TicksPerSecReset;
      origin_valid = 1'b0;
      origin_tick = '0;
      for (int i = 0; i < NSrc; i++) begin
        started[i] = 1'b0;
        first_dev[i] = '0;
        first_frame[i] = '0;
        last_valid[i] = 1'b0;
        last_dev[i] = '0;
        last_frames[i] = '0;
        last_rate[i] = '0;
        last_contig[i] = 1'b0;
        cursor[i] = '0;
      end
      placements_due.delete();
      mismatch_count_o <= 0;
      placements_checked_o <= 0;
      placements_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMaxCorr:   max_corr_q = cfg_wdata_i;
          RegJitterTol: jitter_tol_q = cfg_wdata_i[7:0];
          RegCanonRate: canon_rate_q = cfg_wdata_i;
          RegTicksSec:  ticks_sec_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) placements_due.push_back(place_packet(req_data_i));
      if (res_valid_i && res_ready_i) begin
        placements_checked_o <= placements_checked_o + 1;
        if (placements_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, res_data_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          due = placements_due[0];
          placements_due.delete(0);
          if (due !== res_data_i) begin
            $display("%0t: placement mismatch\n  expected %p\n  actual   %p",
                     $time, due, res_data_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      placements_pending_o <= placements_due.size();
    end
  end

endmodule

// File: sim/audio_packet_timeline_placer_tb.sv
// Testbench top: drives packet requests and registers and reports the verdict.
`timescale 1ns / 1ps

module audio_packet_timeline_placer_tb
  import aptp_pkg::*;
;

  localparam int unsigned StallLimit = 6000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  int unsigned mismatches, pending, checked, idle_cycles;
  logic        calm;

  // Current register values, used to shape well-formed packet streams.
  logic [31:0] canon_now, ticks_now;

  // Per-source stream trackers.
  logic [63:0] next_tick [3];
  logic [63:0] next_dev  [3];
  logic [31:0] src_rate  [3];

  aptp_if #(.T(pkt_in_t))  req_ch ();
  aptp_if #(.T(pkt_out_t)) res_ch ();

  audio_packet_timeline_placer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  aptp_placement_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (req_ch.valid),
    .req_ready_i         (req_ch.ready),
    .req_data_i          (req_ch.data),
    .res_valid_i         (res_ch.valid),
    .res_ready_i         (res_ch.ready),
    .res_data_i          (res_ch.data),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .mismatch_count_o    (mismatches),
    .placements_pending_o(pending),
    .placements_checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one packet request and holds it until accepted, at times with a random gap after it outside the calm phase.
  task automatic send_packet(pkt_in_t p);
    req_ch.valid <= 1'b1;
    req_ch.data  <= p;
    @(posedge clk_i iff (req_ch.valid && req_ch.ready));
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(logic [1:0] src, logic [63:0] ts, logic [63:0] dev,
                             logic [31:0] rate, logic [31:0] frames, logic disc, logic good);
    pkt_in_t p;
    p = '{source_index: src, timestamp_ticks: ts, device_position: dev, source_rate: rate,
          packet_frames: frames, discontinuity_flag: disc, timestamp_good: good};
    send_packet(p);
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i iff (pending == 0));
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] corr, logic [7:0] tol, logic [31:0] canon,
                          logic [31:0] ticks);
    write_reg(RegMaxCorr, corr);
    write_reg(RegJitterTol, {24'd0, tol});
    write_reg(RegCanonRate, canon);
    write_reg(RegTicksSec, ticks);
    cfg_we_i <= 1'b0;
    canon_now = canon;
    ticks_now = ticks;
  endtask

  // One packet: mostly a contiguous stream per source with small wobble, some noise.
  task automatic send_stream_packet();
    int s;
    logic [31:0] frames;
    logic [63:0] ts, wide;
    s = $urandom_range(0, 2);
    if ($urandom_range(0, 9) < 2) begin
      send_fields(2'($urandom_range(0, 3)), rand64(), rand64(), $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return;
    end
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 4))
        0: src_rate[s] = canon_now;
        1: src_rate[s] = 32'd44100;
        2: src_rate[s] = 32'd96000;
        3: src_rate[s] = 32'd16000;
        default: src_rate[s] = 32'd0;
      endcase
    end
    frames = ($urandom_range(0, 40) == 0) ? $urandom : $urandom_range(1, 960);
    ts = next_tick[s];
    case ($urandom_range(0, 9))
      0: ts = ts + $urandom_range(0, 2000000);
      1: ts = ts - $urandom_range(0, 2000000);
      2, 3: ts = ts + $urandom_range(0, 800) - 400;
      default: ;
    endcase
    send_fields(s[1:0], ts, next_dev[s], src_rate[s], frames,
                $urandom_range(0, 19) == 0, $urandom_range(0, 19) != 0);
    wide = (canon_now == 0) ? 64'd0 : 64'(frames) * ticks_now / canon_now;
    next_tick[s] = next_tick[s] + wide;
    wide = (canon_now == 0) ? 64'd0 : 64'(frames) * src_rate[s] / canon_now;
    next_dev[s] = next_dev[s] + wide + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0);
  endtask

  // Result side: random stall bursts, none in the final stretch.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= StallLimit) begin
      $display("Timeout after %0d quiet cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Main sequence.
  initial begin
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegMaxCorr;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    canon_now = CanonRateReset;
    ticks_now = TicksPerSecReset;
    for (int i = 0; i < 3; i++) begin
      next_tick[i] = 64'd5000000 + $urandom_range(0, 100000);
      next_dev[i] = $urandom;
      src_rate[i] = (i == 1) ? 32'd44100 : CanonRateReset;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: origin, drift, late, gap, unreliable stamps, bad index, extremes.
    send_fields(2'd0, 64'd5000000, 64'd1000, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd0, 64'd5100000, 64'd1480, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd0, 64'd5200200, 64'd1960, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd0, 64'd5250000, 64'd2440, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd0, 64'd9000000, 64'd2920, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd0, 64'd9100000, 64'd99999, 32'd48000, 32'd480, 1'b1, 1'b1);
    send_fields(2'd1, 64'd0, 64'd500, 32'd44100, 32'd441, 1'b0, 1'b1);
    send_fields(2'd1, 64'd6000000, 64'd100, 32'd44100, 32'd441, 1'b0, 1'b1);
    send_fields(2'd1, 64'd6100000, 64'd541, 32'd0, 32'd441, 1'b0, 1'b0);
    send_fields(2'd3, 64'd9200000, 64'd3400, 32'd48000, 32'd480, 1'b0, 1'b1);
    send_fields(2'd2, '1, '1, '1, '1, 1'b1, 1'b1);
    send_fields(2'd2, '1, 64'd0, 32'd1, '1, 1'b0, 1'b0);
    send_fields(2'd2, 64'd0, '1, 32'd0, 32'd0, 1'b0, 1'b1);
    send_fields(2'd0, '1, 64'd0, '1, 32'd0, 1'b1, 1'b0);
    drain();

    // Phases over register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(32'd480, 8'd2, 32'd48000, 32'd10000000);
        1: set_regs(32'd0, 8'd255, 32'd48000, 32'd10000000);
        2: set_regs('1, 8'd0, 32'd1, 32'd1);
        3: set_regs(32'd20, 8'd8, '1, '1);
        4: set_regs($urandom_range(0, 1000), 8'($urandom_range(0, 16)), 32'd44100,
                    32'd1000000);
        default: set_regs(32'd480, 8'd2, 32'd48000, 32'd10000000);
      endcase
      calm = (ph == 5);
      repeat (150) send_stream_packet();
      drain();
    end

    $display("Sent about 915 packets over six register settings; %0d placements checked.",
             checked);
    $display("Covered drift, jitter snaps, late and gapped packets and bad timestamps.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
